// ===== design/sbi_pkg.sv =====
// Shared constants for the segment/box intersection pipeline.
package sbi_pkg;

  localparam int LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd7;

endpackage

// ===== design/sbi_side.sv =====
// One box side: deltas, near-zero test, pipelined quotient, crossing point and span test.
module sbi_side import sbi_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic [F+6:0]        en_i,
  input  logic [LIMIT_W-1:0]  limit_i,
  input  logic signed [W-1:0] sa_i,
  input  logic signed [W-1:0] ea_i,
  input  logic signed [W-1:0] side_i,
  input  logic signed [W-1:0] mina_i,
  input  logic signed [W-1:0] maxa_i,
  input  logic signed [W-1:0] sb_i,
  input  logic signed [W-1:0] eb_i,
  input  logic signed [W-1:0] minb_i,
  input  logic signed [W-1:0] maxb_i,
  output logic                hit_o
);

  localparam int LS    = F + 7;
  localparam int RW    = W + 2;
  localparam int CW    = (W + 1 > LIMIT_W) ? W + 1 : LIMIT_W;
  localparam int PW    = F + W + 3;
  localparam int S_MAG = 1;
  localparam int S_REJ = 2;
  localparam int S_DIV = 3;
  localparam int S_SEL = F + 4;
  localparam int S_MUL = F + 5;
  localparam int S_ADD = F + 6;

  logic signed [W:0]   da_q, num_q;
  logic [W:0]          a_q;
  logic                span_q [LS];
  logic                nz_q   [LS];
  logic                mis_q  [LS];
  logic                rej_q  [LS];
  logic                kill_q [LS];
  logic [W:0]          b_q    [LS];
  logic signed [W:0]   db_q   [LS];
  logic signed [W-1:0] sb_q   [LS];
  logic signed [W-1:0] minb_q [LS];
  logic signed [W-1:0] maxb_q [LS];
  logic [RW-1:0]       r_q    [LS];
  logic [F:0]          q_q    [LS];
  logic [F:0]          t_q;
  logic signed [PW-1:0] prod_q;
  logic signed [W+1:0] col_q;

  logic signed [W:0]   da_d, num_d, db_d;
  logic                span_d;
  logic [W:0]          mag_a, mag_b;
  logic                nz_d, mis_d;
  logic [RW-1:0]       rin [F+1];
  logic [RW-1:0]       rnx [F+1];
  logic                ge  [F+1];
  logic [F:0]          q_sel;
  logic                over, kill_d;
  logic [F:0]          t_d;

  always_comb begin
    da_d   = $signed({ea_i[W-1], ea_i}) - $signed({sa_i[W-1], sa_i});
    db_d   = $signed({eb_i[W-1], eb_i}) - $signed({sb_i[W-1], sb_i});
    num_d  = $signed({side_i[W-1], side_i}) - $signed({sa_i[W-1], sa_i});
    span_d = (sa_i >= mina_i) && (sa_i <= maxa_i);
  end

  always_comb begin
    mag_a = num_q[W] ? (W+1)'(-num_q) : num_q;
    mag_b = da_q[W] ? (W+1)'(-da_q) : da_q;
    nz_d  = (CW'(mag_b) < CW'(limit_i)) || (mag_b == '0);
    mis_d = num_q[W] != da_q[W];
  end

  // restoring division, one quotient bit per stage; first stage is the integer bit
  always_comb begin
    for (int k = 0; k <= F; k++) begin
      if (k == 0) begin
        rin[k] = r_q[S_DIV-1];
      end else begin
        rin[k] = {r_q[S_DIV+k-1][RW-2:0], 1'b0};
      end
      ge[k]  = rin[k] >= {1'b0, b_q[S_DIV+k-1]};
      rnx[k] = ge[k] ? rin[k] - {1'b0, b_q[S_DIV+k-1]} : rin[k];
    end
  end

  always_comb begin
    q_sel  = q_q[S_SEL-1];
    over   = q_sel[F] && (|q_sel[F-1:0]);
    kill_d = nz_q[S_SEL-1] ? !span_q[S_SEL-1]
                           : (rej_q[S_SEL-1] || over || ((|q_sel) && mis_q[S_SEL-1]));
    t_d    = nz_q[S_SEL-1] ? '0 : q_sel;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      da_q      <= da_d;
      num_q     <= num_d;
      db_q[0]   <= db_d;
      span_q[0] <= span_d;
      nz_q[0]   <= 1'b0;
      mis_q[0]  <= 1'b0;
      rej_q[0]  <= 1'b0;
      kill_q[0] <= 1'b0;
      b_q[0]    <= '0;
      sb_q[0]   <= sb_i;
      minb_q[0] <= minb_i;
      maxb_q[0] <= maxb_i;
    end
    for (int s = 1; s < LS; s++) begin
      if (en_i[s]) begin
        span_q[s] <= span_q[s-1];
        nz_q[s]   <= (s == S_MAG) ? nz_d : nz_q[s-1];
        mis_q[s]  <= (s == S_MAG) ? mis_d : mis_q[s-1];
        // integer part of two or more
        rej_q[s]  <= (s == S_REJ) ? ({1'b0, a_q} >= {b_q[S_MAG], 1'b0}) : rej_q[s-1];
        kill_q[s] <= (s == S_SEL) ? kill_d : kill_q[s-1];
        b_q[s]    <= (s == S_MAG) ? mag_b : b_q[s-1];
        db_q[s]   <= db_q[s-1];
        sb_q[s]   <= sb_q[s-1];
        minb_q[s] <= minb_q[s-1];
        maxb_q[s] <= maxb_q[s-1];
      end
    end
    if (en_i[S_MAG]) begin
      a_q <= mag_a;
    end
    if (en_i[S_REJ]) begin
      r_q[S_REJ] <= {1'b0, a_q};
      q_q[S_REJ] <= '0;
    end
    for (int k = 0; k <= F; k++) begin
      if (en_i[S_DIV+k]) begin
        r_q[S_DIV+k] <= rnx[k];
        q_q[S_DIV+k] <= {q_q[S_DIV+k-1][F-1:0], ge[k]};
      end
    end
    if (en_i[S_SEL]) begin
      t_q <= t_d;
    end
    if (en_i[S_MUL]) begin
      prod_q <= $signed({1'b0, t_q}) * db_q[S_SEL];
    end
    if (en_i[S_ADD]) begin
      col_q <= $signed({{2{sb_q[S_MUL][W-1]}}, sb_q[S_MUL]}) + $signed(prod_q[F+W+1:F]);
    end
  end

  assign hit_o = !kill_q[S_ADD]
              && (col_q >= $signed({{2{minb_q[S_ADD][W-1]}}, minb_q[S_ADD]}))
              && (col_q <= $signed({{2{maxb_q[S_ADD][W-1]}}, maxb_q[S_ADD]}));

endmodule

// ===== design/segment_box_intersection_unit.sv =====
// Top level: segment against axis-aligned box, four side lanes and stall-aware pipeline.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid_i, in_stall_o, 8 coord ports | in
//  result   | out_valid_o, out_stall_i, hit_o       | out
//  config   | cfg_we_i, cfg_wdata_i                 | in
//
// Accepts one item per cycle unless in_stall_o is raised; each lane has a
// one-bit-per-stage quotient chain (FRAC_BITS + 1 stages).
// Reset clears the valid bits and loads the near-zero limit with 7.
// Each stage holds while its successor is full and stalled, so bubbles
// close up and nothing is dropped or repeated.
module segment_box_intersection_unit import sbi_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [LIMIT_W-1:0]            cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o
);

  localparam int LS = FRAC_BITS + 7;
  localparam int NS = LS + 1;

  logic [LIMIT_W-1:0] limit_q;
  logic [NS-1:0]      v_q;
  logic [NS-1:0]      adv;
  logic [3:0]         lane_hit;
  logic               hit_q;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int s = NS - 2; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      v_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      for (int s = 0; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      hit_q <= |lane_hit;
    end
  end

  sbi_side #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_side_x0 (
    .clk_i, .en_i(adv[LS-1:0]), .limit_i(limit_q),
    .sa_i(start_x_i), .ea_i(end_x_i), .side_i(box_min_x_i),
    .mina_i(box_min_x_i), .maxa_i(box_max_x_i),
    .sb_i(start_y_i), .eb_i(end_y_i), .minb_i(box_min_y_i), .maxb_i(box_max_y_i),
    .hit_o(lane_hit[0])
  );

  sbi_side #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_side_x1 (
    .clk_i, .en_i(adv[LS-1:0]), .limit_i(limit_q),
    .sa_i(start_x_i), .ea_i(end_x_i), .side_i(box_max_x_i),
    .mina_i(box_min_x_i), .maxa_i(box_max_x_i),
    .sb_i(start_y_i), .eb_i(end_y_i), .minb_i(box_min_y_i), .maxb_i(box_max_y_i),
    .hit_o(lane_hit[1])
  );

  sbi_side #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_side_y0 (
    .clk_i, .en_i(adv[LS-1:0]), .limit_i(limit_q),
    .sa_i(start_y_i), .ea_i(end_y_i), .side_i(box_min_y_i),
    .mina_i(box_min_y_i), .maxa_i(box_max_y_i),
    .sb_i(start_x_i), .eb_i(end_x_i), .minb_i(box_min_x_i), .maxb_i(box_max_x_i),
    .hit_o(lane_hit[2])
  );

  sbi_side #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_side_y1 (
    .clk_i, .en_i(adv[LS-1:0]), .limit_i(limit_q),
    .sa_i(start_y_i), .ea_i(end_y_i), .side_i(box_max_y_i),
    .mina_i(box_min_y_i), .maxa_i(box_max_y_i),
    .sb_i(start_x_i), .eb_i(end_x_i), .minb_i(box_min_x_i), .maxb_i(box_max_x_i),
    .hit_o(lane_hit[3])
  );

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];
  assign hit_o       = hit_q;

endmodule

// ===== design/sbi_checker.sv =====
// Port-level checks for the segment/box intersection unit, bound to the top level.
module sbi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
    else $error("stalled result changed");

  // input backs up only when the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // a free output never pushes back on the input
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("valid result during reset");

endmodule

bind segment_box_intersection_unit sbi_checker u_sbi_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .hit_o
);
